>>> src/image_mirror_flip_core_macros.svh
// Assertion helpers for the mirror/flip engine.
// Expects clk and rst_n in the scope of each use.
`ifndef IMAGE_MIRROR_FLIP_CORE_MACROS_SVH
`define IMAGE_MIRROR_FLIP_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define IMF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define IMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/imf_pkg.sv
// Shared constants and types of the mirror/flip engine.
// No dependencies.
package imf_pkg;

    // default frame limits
    localparam int IMF_MAX_WIDTH  = 128;
    localparam int IMF_MAX_HEIGHT = 128;
    localparam int IMF_MAX_BPP    = 4;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_PIXEL   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR_HORIZONTAL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR_VERTICAL   = 3'd4;

    localparam logic [7:0] RST_IMAGE_WIDTH     = 8'd128;
    localparam logic [7:0] RST_IMAGE_HEIGHT    = 8'd128;
    localparam logic [2:0] RST_BYTES_PER_PIXEL = 3'd4;

    // cycles the derived frame size needs after a register write
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    // frame store access issued by the address pipeline
    typedef struct packed {
        logic wr;
        logic rd;
        logic last;
    } imf_mem_ctl_t;

endpackage

>>> src/imf_frame_ram.sv
// Single-port byte frame store, one access per cycle, registered read data.
// Depends on imf_pkg for the default depth.
module imf_frame_ram
    import imf_pkg::*;
#(
    parameter int DEPTH = IMF_MAX_WIDTH * IMF_MAX_HEIGHT * IMF_MAX_BPP
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/imf_addr_gen.sv
// Load/fetch counters and the three-stage frame store address pipeline.
// Depends on imf_pkg (imf_mem_ctl_t).
module imf_addr_gen
    import imf_pkg::*;
#(
    parameter int MAX_WIDTH           = IMF_MAX_WIDTH,
    parameter int MAX_HEIGHT          = IMF_MAX_HEIGHT,
    parameter int MAX_BYTES_PER_PIXEL = IMF_MAX_BPP,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_BYTES_PER_PIXEL,
    localparam int AB    = $clog2(DEPTH),
    localparam int TB    = $clog2(DEPTH + 1),
    localparam int WB    = $clog2(MAX_WIDTH + 1),
    localparam int HB    = $clog2(MAX_HEIGHT + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          issue,
    input  logic          operation,
    input  logic [7:0]    pixel_byte,
    input  logic [WB-1:0] img_w,
    input  logic [HB-1:0] img_h,
    input  logic [2:0]    img_bpp,
    input  logic          mirror_h,
    input  logic          mirror_v,
    input  logic [TB-1:0] frame_total,
    output imf_mem_ctl_t  mem_ctl,
    output logic [AB-1:0] mem_addr,
    output logic [7:0]    mem_wdata
);

    localparam int RB  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CB  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ChB = $clog2(MAX_BYTES_PER_PIXEL);
    localparam int PB  = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;

    // running counters
    logic [AB-1:0]  load_pos_reg, load_pos_next;
    logic [RB-1:0]  row_reg, row_next;
    logic [CB-1:0]  col_reg, col_next;
    logic [ChB-1:0] chan_reg, chan_next;

    logic [AB-1:0]  pos_cur;
    logic [TB-1:0]  pos_inc;
    logic [RB-1:0]  row_cur, src_row;
    logic [CB-1:0]  col_cur, src_col;
    logic [ChB-1:0] chan_cur;
    logic [WB-1:0]  w_last;
    logic [HB-1:0]  h_last;
    logic [2:0]     bpp_last;
    logic           chan_wrap, col_wrap, row_wrap, frame_last;

    // stage 1: source row/column
    logic           s1_vld_reg, s1_load_reg, s1_last_reg;
    logic [7:0]     s1_data_reg;
    logic [AB-1:0]  s1_laddr_reg;
    logic [RB-1:0]  s1_row_reg;
    logic [CB-1:0]  s1_col_reg;
    logic [ChB-1:0] s1_chan_reg;

    // stage 2: pixel index
    logic             s2_vld_reg, s2_load_reg, s2_last_reg;
    logic [7:0]       s2_data_reg;
    logic [AB-1:0]    s2_laddr_reg;
    logic [PB-1:0]    s2_pix_reg, s2_pix_next;
    logic [ChB-1:0]   s2_chan_reg;
    logic [RB+WB-1:0] row_base;

    // stage 3: byte address
    logic          s3_vld_reg, s3_load_reg, s3_last_reg;
    logic [7:0]    s3_data_reg;
    logic [AB-1:0] s3_addr_reg, s3_addr_next;
    logic [AB-1:0] pix_a, pix_scaled;

    // counters restart when a register change left them out of the frame
    always_comb
    begin
        w_last   = img_w - WB'(1);
        h_last   = img_h - HB'(1);
        bpp_last = img_bpp - 3'd1;

        pos_cur  = (TB'(load_pos_reg) >= frame_total) ? '0 : load_pos_reg;
        row_cur  = (HB'(row_reg) >= img_h) ? '0 : row_reg;
        col_cur  = (WB'(col_reg) >= img_w) ? '0 : col_reg;
        chan_cur = (3'(chan_reg) >= img_bpp) ? '0 : chan_reg;

        src_row = mirror_v ? RB'(h_last - HB'(row_cur)) : row_cur;
        src_col = mirror_h ? CB'(w_last - WB'(col_cur)) : col_cur;

        chan_wrap  = (3'(chan_cur) == bpp_last);
        col_wrap   = (WB'(col_cur) == w_last);
        row_wrap   = (HB'(row_cur) == h_last);
        frame_last = chan_wrap && col_wrap && row_wrap;

        pos_inc = TB'(pos_cur) + TB'(1);

        load_pos_next = load_pos_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        chan_next     = chan_reg;
        if (issue && !operation)
        begin
            load_pos_next = (pos_inc >= frame_total) ? '0 : AB'(pos_inc);
        end
        if (issue && operation)
        begin
            chan_next = chan_wrap ? '0 : chan_cur + ChB'(1);
            col_next  = col_cur;
            row_next  = row_cur;
            if (chan_wrap)
            begin
                col_next = col_wrap ? '0 : col_cur + CB'(1);
                if (col_wrap)
                begin
                    row_next = row_wrap ? '0 : row_cur + RB'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            chan_reg     <= '0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
        end
        else
        begin
            load_pos_reg <= load_pos_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            chan_reg     <= chan_next;
            s1_vld_reg   <= issue;
            s2_vld_reg   <= s1_vld_reg;
            s3_vld_reg   <= s2_vld_reg;
        end
    end

    // stage 2 multiply, stage 3 scale by bytes per pixel
    assign row_base    = s1_row_reg * img_w;
    assign s2_pix_next = PB'(row_base) + PB'(s1_col_reg);

    always_comb
    begin
        pix_a = AB'(s2_pix_reg);
        case (img_bpp)
            3'd2:    pix_scaled = pix_a << 1;
            3'd3:    pix_scaled = (pix_a << 1) + pix_a;
            default: pix_scaled = pix_a << 2;
        endcase
        s3_addr_next = s2_load_reg ? s2_laddr_reg : pix_scaled + AB'(s2_chan_reg);
    end

    always_ff @(posedge clk)
    begin
        s1_load_reg  <= !operation;
        s1_last_reg  <= frame_last;
        s1_data_reg  <= pixel_byte;
        s1_laddr_reg <= pos_cur;
        s1_row_reg   <= src_row;
        s1_col_reg   <= src_col;
        s1_chan_reg  <= chan_cur;

        s2_load_reg  <= s1_load_reg;
        s2_last_reg  <= s1_last_reg;
        s2_data_reg  <= s1_data_reg;
        s2_laddr_reg <= s1_laddr_reg;
        s2_pix_reg   <= s2_pix_next;
        s2_chan_reg  <= s1_chan_reg;

        s3_load_reg  <= s2_load_reg;
        s3_last_reg  <= s2_last_reg;
        s3_data_reg  <= s2_data_reg;
        s3_addr_reg  <= s3_addr_next;
    end

    assign mem_ctl.wr   = s3_vld_reg && s3_load_reg;
    assign mem_ctl.rd   = s3_vld_reg && !s3_load_reg;
    assign mem_ctl.last = s3_last_reg;
    assign mem_addr     = s3_addr_reg;
    assign mem_wdata    = s3_data_reg;

endmodule

>>> src/image_mirror_flip_core.sv
// Frame mirror/flip engine: loads bytes in raster order, fetches them mirrored.
// A fetch runs through the address stages, then the store read register, to its beat.
// Throughput: one item (load or fetch) per cycle while busy is low, no receiver stall;
// stages are source row/column, row multiply, bytes-per-pixel scale, then the
// single-port store access. Reset: counters zero, registers at defaults, store
// undefined; busy after reset and each register write while the frame size settles.
`include "image_mirror_flip_core_macros.svh"

module image_mirror_flip_core
    import imf_pkg::*;
#(
    parameter int MAX_WIDTH           = IMF_MAX_WIDTH,
    parameter int MAX_HEIGHT          = IMF_MAX_HEIGHT,
    parameter int MAX_BYTES_PER_PIXEL = IMF_MAX_BPP
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // command channel
    input  logic                   start,
    output logic                   busy,
    input  logic                   operation,
    input  logic [7:0]             pixel_byte,
    // result strobe
    output logic                   out_valid,
    output logic [7:0]             out_byte,
    output logic                   frame_end,
    // register write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_BYTES_PER_PIXEL;
    localparam int AB    = $clog2(DEPTH);
    localparam int TB    = $clog2(DEPTH + 1);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int AREA  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ARB   = $clog2(AREA + 1);

    // ---------------- configuration registers ----------------
    logic [7:0] width_reg, width_next;
    logic [7:0] height_reg, height_next;
    logic [2:0] bpp_reg, bpp_next;
    logic       mirror_h_reg, mirror_h_next;
    logic       mirror_v_reg, mirror_v_next;
    logic [1:0] settle_reg, settle_next;
    logic       cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // register decode; unknown indexes are dropped
    always_comb
    begin
        width_next    = width_reg;
        height_next   = height_reg;
        bpp_next      = bpp_reg;
        mirror_h_next = mirror_h_reg;
        mirror_v_next = mirror_v_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:       width_next    = cfg_wdata;
                CFG_IMAGE_HEIGHT:      height_next   = cfg_wdata;
                CFG_BYTES_PER_PIXEL:   bpp_next      = cfg_wdata[2:0];
                CFG_MIRROR_HORIZONTAL: mirror_h_next = cfg_wdata[0];
                CFG_MIRROR_VERTICAL:   mirror_v_next = cfg_wdata[0];
                default:               ;
            endcase
        end
    end

    // settle count covers the two registered products below
    always_comb
    begin
        if (cfg_write)
        begin
            settle_next = SETTLE_CYCLES;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_next = settle_reg - 2'd1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= RST_IMAGE_WIDTH;
            height_reg   <= RST_IMAGE_HEIGHT;
            bpp_reg      <= RST_BYTES_PER_PIXEL;
            mirror_h_reg <= 1'b0;
            mirror_v_reg <= 1'b0;
            settle_reg   <= SETTLE_CYCLES;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            bpp_reg      <= bpp_next;
            mirror_h_reg <= mirror_h_next;
            mirror_v_reg <= mirror_v_next;
            settle_reg   <= settle_next;
        end
    end

    // items wait while a register write is on the port or sizes settle
    assign busy = cfg_valid || (settle_reg != 2'd0);

    // ---------------- effective frame geometry ----------------
    logic [31:0]        w32, h32, b32;
    logic [WB-1:0]      img_w;
    logic [HB-1:0]      img_h;
    logic [2:0]         img_bpp;
    logic [WB+HB-1:0]   area_prod;
    logic [ARB-1:0]     area_reg;
    logic [ARB+2:0]     total_prod;
    logic [TB-1:0]      total_reg;

    // clamp out-of-range register values to the supported limits
    always_comb
    begin
        if (width_reg == 8'd0)
        begin
            w32 = 32'd1;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w32 = 32'(MAX_WIDTH);
        end
        else
        begin
            w32 = 32'(width_reg);
        end

        if (height_reg == 8'd0)
        begin
            h32 = 32'd1;
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            h32 = 32'(MAX_HEIGHT);
        end
        else
        begin
            h32 = 32'(height_reg);
        end

        if (bpp_reg < 3'd2)
        begin
            b32 = 32'd2;
        end
        else if (32'(bpp_reg) > 32'(MAX_BYTES_PER_PIXEL))
        begin
            b32 = 32'(MAX_BYTES_PER_PIXEL);
        end
        else
        begin
            b32 = 32'(bpp_reg);
        end

        img_w   = WB'(w32);
        img_h   = HB'(h32);
        img_bpp = 3'(b32);
    end

    // frame size in bytes, two registered steps
    assign area_prod  = img_w * img_h;
    assign total_prod = area_reg * img_bpp;

    always_ff @(posedge clk)
    begin
        area_reg  <= ARB'(area_prod);
        total_reg <= TB'(total_prod);
    end

    // ---------------- address pipeline and frame store ----------------
    imf_mem_ctl_t  mem_ctl;
    logic [AB-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic          issue;

    assign issue = start && !busy;

    imf_addr_gen #(
        .MAX_WIDTH           (MAX_WIDTH),
        .MAX_HEIGHT          (MAX_HEIGHT),
        .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
    ) u_addr_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .operation   (operation),
        .pixel_byte  (pixel_byte),
        .img_w       (img_w),
        .img_h       (img_h),
        .img_bpp     (img_bpp),
        .mirror_h    (mirror_h_reg),
        .mirror_v    (mirror_v_reg),
        .frame_total (total_reg),
        .mem_ctl     (mem_ctl),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata)
    );

    imf_frame_ram #(
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .wr_en (mem_ctl.wr),
        .rd_en (mem_ctl.rd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (out_byte)
    );

    // ---------------- result strobe ----------------
    logic out_valid_reg;
    logic frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            frame_end_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= mem_ctl.rd;
            frame_end_reg <= mem_ctl.rd && mem_ctl.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign frame_end = frame_end_reg;

    // ---------------- checks ----------------
    `IMF_ASSERT_IMP(a_beat_from_fetch, out_valid, $past(start && !busy && operation, 4), "result beat without a fetch four cycles earlier")
    `IMF_ASSERT_IMP(a_end_on_beat, frame_end, out_valid, "frame_end outside a result beat")
    `IMF_ASSERT_NEXT(a_cfg_holds_items, cfg_valid && cfg_ready, busy, "item window open right after a register write")

endmodule

>>> bench/mirror_flip_checker.sv
// Bench package and result checker for image_mirror_flip_core.
// Depends on imf_pkg; the bench package below is shared with tb.
`timescale 1ns / 1ps

package mirror_flip_bench_pkg;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } mirror_op_t;

    function automatic int unsigned clamp_span(int unsigned v, int unsigned lo,
                                               int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

endpackage

module mirror_flip_checker
    import imf_pkg::*;
    import mirror_flip_bench_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic                   operation,
    input  logic [7:0]             pixel_byte,
    input  logic                   out_valid,
    input  logic [7:0]             out_byte,
    input  logic                   frame_end,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     fail_count,
    output int                     pending_beats
);

    localparam int STORE_BYTES = IMF_MAX_WIDTH * IMF_MAX_HEIGHT * IMF_MAX_BPP;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_last;
    } mirror_beat_t;

    // shadow registers and counters
    logic [7:0]   width_reg;
    logic [7:0]   height_reg;
    logic [2:0]   bpp_reg;
    logic         flip_h;
    logic         flip_v;
    int unsigned  load_pos;
    int unsigned  fetch_row;
    int unsigned  fetch_col;
    int unsigned  fetch_chan;
    logic [7:0]   frame_mem [0:STORE_BYTES-1];
    mirror_beat_t mirrored_q [$];
    int           beat_count;
    int           reported;

    task automatic note_failure(input string msg);
        fail_count++;
        if (reported < 10)
        begin
            reported++;
            $display("mirror_flip_checker: %s", msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     = RST_IMAGE_WIDTH;
            height_reg    = RST_IMAGE_HEIGHT;
            bpp_reg       = RST_BYTES_PER_PIXEL;
            flip_h        = 1'b0;
            flip_v        = 1'b0;
            load_pos      = 0;
            fetch_row     = 0;
            fetch_col     = 0;
            fetch_chan    = 0;
            beat_count    = 0;
            reported      = 0;
            fail_count    = 0;
            mirrored_q.delete();
            pending_beats = 0;
        end
        else
        begin
            // result beat, compared against the oldest prediction
            if (out_valid)
            begin : check_result
                mirror_beat_t want;
                if (mirrored_q.size() == 0)
                    note_failure($sformatf("unexpected beat: byte %02h end %b",
                                           out_byte, frame_end));
                else
                begin
                    want = mirrored_q.pop_front();
                    if (out_byte !== want.data || frame_end !== want.frame_last)
                        note_failure($sformatf(
                            "beat %0d: expected byte %02h end %b, got byte %02h end %b",
                            beat_count, want.data, want.frame_last, out_byte, frame_end));
                end
                beat_count++;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:       width_reg  = cfg_wdata;
                    CFG_IMAGE_HEIGHT:      height_reg = cfg_wdata;
                    CFG_BYTES_PER_PIXEL:   bpp_reg    = cfg_wdata[2:0];
                    CFG_MIRROR_HORIZONTAL: flip_h     = cfg_wdata[0];
                    CFG_MIRROR_VERTICAL:   flip_v     = cfg_wdata[0];
                    default: ;
                endcase
            end

            if (start && !busy)
            begin : predict
                int unsigned  w;
                int unsigned  h;
                int unsigned  bpp;
                int unsigned  frame_bytes;
                int unsigned  src_row;
                int unsigned  src_col;
                mirror_beat_t beat;
                w           = clamp_span(width_reg, 1, IMF_MAX_WIDTH);
                h           = clamp_span(height_reg, 1, IMF_MAX_HEIGHT);
                bpp         = clamp_span(bpp_reg, 2, IMF_MAX_BPP);
                frame_bytes = w * h * bpp;
                if (operation == OP_LOAD)
                begin
                    if (load_pos >= frame_bytes)
                        load_pos = 0;
                    frame_mem[load_pos] = pixel_byte;
                    load_pos++;
                    if (load_pos >= frame_bytes)
                        load_pos = 0;
                end
                else
                begin
                    // counters left beyond a shrunken frame restart
                    if (fetch_row >= h)
                        fetch_row = 0;
                    if (fetch_col >= w)
                        fetch_col = 0;
                    if (fetch_chan >= bpp)
                        fetch_chan = 0;
                    src_row = flip_v ? h - 1 - fetch_row : fetch_row;
                    src_col = flip_h ? w - 1 - fetch_col : fetch_col;
                    beat.data       = frame_mem[(src_row * w + src_col) * bpp + fetch_chan];
                    beat.frame_last = (fetch_row == h - 1) && (fetch_col == w - 1) &&
                                      (fetch_chan == bpp - 1);
                    mirrored_q.push_back(beat);
                    fetch_chan++;
                    if (fetch_chan >= bpp)
                    begin
                        fetch_chan = 0;
                        fetch_col++;
                        if (fetch_col >= w)
                        begin
                            fetch_col = 0;
                            fetch_row++;
                            if (fetch_row >= h)
                                fetch_row = 0;
                        end
                    end
                end
            end

            pending_beats = mirrored_q.size();
        end
    end

endmodule

>>> bench/tb.sv
// Top of the bench for image_mirror_flip_core: clock, reset, stimulus, verdict.
// Depends on imf_pkg, mirror_flip_bench_pkg and mirror_flip_checker.
`timescale 1ns / 1ps

module tb
    import imf_pkg::*;
    import mirror_flip_bench_pkg::*;
();

    // generous cap on the run for a few thousand commands with gaps
    localparam int CYCLE_LIMIT = 500000;
    // quiet cycles after the last beat: covers loads in the 3-stage address pipeline
    localparam int DRAIN_HOLD  = 10;
    localparam int RANDOM_ITEMS = 1200;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   operation;
    logic [7:0]             pixel_byte;
    logic                   out_valid;
    logic [7:0]             out_byte;
    logic                   frame_end;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int          fail_count;
    int          pending_beats;
    int          burst_left;
    int          cycle_count;
    // bytes in the frame as currently configured (after clamping)
    int unsigned frame_bytes;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    image_mirror_flip_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .pixel_byte (pixel_byte),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .frame_end  (frame_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    mirror_flip_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .pixel_byte    (pixel_byte),
        .out_valid     (out_valid),
        .out_byte      (out_byte),
        .frame_end     (frame_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    // Send one command beat. Commands go out in bursts; between bursts start
    // drops for a random gap so idle cycles land on every pipeline stage.
    // Inputs move on the falling edge; busy is sampled on the rising edge.
    task automatic issue_cmd(input mirror_op_t op, input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            // now and then a long stretch with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        start      <= 1'b1;
        operation  <= op;
        pixel_byte <= data;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
    endtask

    // Stop sending, wait until every predicted beat has come out, then give
    // loads still in the pipeline time to land. pending_beats is read on the
    // falling edge, well clear of the checker's rising-edge update.
    task automatic drain_and_hold();
        @(negedge clk);
        start <= 1'b0;
        burst_left = 0;
        while (pending_beats != 0)
            @(negedge clk);
        repeat (DRAIN_HOLD) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Program all five registers from raw values; out-of-range sizes and the
    // upper bits of the narrow registers go out as given, the block clamps
    // and masks. Occasionally an unused index is written as well.
    task automatic configure(input logic [7:0] w_raw, input logic [7:0] h_raw,
                             input logic [7:0] bpp_raw, input logic [7:0] mh_raw,
                             input logic [7:0] mv_raw);
        logic [CFG_INDEX_W-1:0] spare_idx;
        drain_and_hold();
        write_reg(CFG_IMAGE_WIDTH, w_raw);
        write_reg(CFG_IMAGE_HEIGHT, h_raw);
        write_reg(CFG_BYTES_PER_PIXEL, bpp_raw);
        write_reg(CFG_MIRROR_HORIZONTAL, mh_raw);
        write_reg(CFG_MIRROR_VERTICAL, mv_raw);
        if ($urandom_range(0, 3) == 0)
        begin
            spare_idx = CFG_INDEX_W'($urandom_range(CFG_MIRROR_VERTICAL + 1,
                                                    2**CFG_INDEX_W - 1));
            write_reg(spare_idx, 8'($urandom));
        end
        frame_bytes = clamp_span(w_raw, 1, IMF_MAX_WIDTH) *
                      clamp_span(h_raw, 1, IMF_MAX_HEIGHT) *
                      clamp_span(bpp_raw[2:0], 2, IMF_MAX_BPP);
    endtask

    // A full frame of consecutive loads covers every address a fetch can
    // reach, wherever the load counter happens to stand, so fetches that
    // follow never touch an unwritten byte.
    task automatic load_frame();
        repeat (frame_bytes) issue_cmd(OP_LOAD, 8'($urandom));
    endtask

    initial
    begin : stimulus
        int          random_items;
        int          mix_len;
        int          shape;
        logic [7:0]  w_raw;
        logic [7:0]  h_raw;
        logic [7:0]  bpp_raw;

        rst_n      = 1'b0;
        start      = 1'b0;
        operation  = OP_LOAD;
        pixel_byte = 8'h00;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_IMAGE_WIDTH;
        cfg_wdata  = 8'h00;
        burst_left = 0;
        random_items = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero sizes and a too-small pixel clamp to a 1x1 frame of
        // two bytes; mirror registers carry junk in their upper bits. Three
        // fetches: end marker on the second, then the counters wrap.
        configure(8'h00, 8'h00, 8'hF9, 8'hFF, 8'h03);
        issue_cmd(OP_LOAD, 8'h00);
        issue_cmd(OP_LOAD, 8'hFF);
        repeat (3) issue_cmd(OP_FETCH, 8'hFF);

        // Directed: 3x1 frame, both mirrors; odd centre column stays put.
        configure(8'd3, 8'd1, 8'd2, 8'd1, 8'd1);
        load_frame();
        repeat (frame_bytes) issue_cmd(OP_FETCH, 8'h00);

        // Directed: 1x3 frame, vertical mirror only (upper bit ignored on
        // the horizontal one); odd centre row stays put. The frame is left
        // partly read so the next setting starts from moved counters.
        configure(8'd1, 8'd3, 8'd2, 8'hFE, 8'd1);
        load_frame();
        repeat (4) issue_cmd(OP_FETCH, 8'h00);

        // Random phases: new setting, full frame load with random content,
        // then a mix that is mostly fetches with loads interleaved.
        while (random_items < RANDOM_ITEMS)
        begin
            shape = $urandom_range(0, 9);
            case (shape)
                0:
                begin
                    // widest row, one line
                    w_raw = ($urandom_range(0, 1) == 0) ? 8'd128 : 8'($urandom_range(129, 255));
                    h_raw = 8'($urandom_range(0, 1));
                end
                1:
                begin
                    // tallest column, one pixel wide
                    w_raw = 8'($urandom_range(0, 1));
                    h_raw = ($urandom_range(0, 1) == 0) ? 8'd128 : 8'($urandom_range(129, 255));
                end
                default:
                begin
                    w_raw = 8'($urandom_range(0, 8));
                    h_raw = 8'($urandom_range(0, 8));
                end
            endcase
            bpp_raw = 8'($urandom);
            configure(w_raw, h_raw, bpp_raw, 8'($urandom), 8'($urandom));
            load_frame();
            mix_len = frame_bytes + $urandom_range(0, frame_bytes + 8);
            for (int i = 0; i < mix_len; i++)
            begin
                // hold-off: let the pipeline run dry mid-phase
                if ($urandom_range(0, 99) == 0)
                    drain_and_hold();
                if ($urandom_range(0, 9) < 6)
                    issue_cmd(OP_FETCH, 8'($urandom));
                else
                    issue_cmd(OP_LOAD, 8'($urandom));
            end
            random_items += frame_bytes + mix_len;
        end

        drain_and_hold();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
